/* hdl/fsta_pkg.sv */
// Shared types, constants and helpers for the free segment table allocator.
// No dependencies; imported by free_segment_table_allocator, fsta_checker and testbench.
package fsta_pkg;

    localparam int unsigned DEPTH = 256;
    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = IDX_W + 1;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned ENT_W = 2 * ADDR_W;
    localparam logic [ADDR_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;
    localparam logic FIT_FIRST = 1'b0;
    localparam logic FIT_BEST  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_NOFIT = 2'd1,
        STAT_LOST = 2'd2,
        STAT_ZERO = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHUP,
        S_SHDN,
        S_INS,
        S_DONE
    } state_t;

    function automatic logic [ADDR_W-1:0] sat_add(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ADDR_W] ? ALL_ONES : s[ADDR_W-1:0];
    endfunction

endpackage

/* hdl/fsta_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module fsta_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/free_segment_table_allocator.sv */
// Free segment table allocator top level: address-sorted segment table in one RAM.
// Depends on fsta_pkg and fsta_ram.
//
//  channel   beat marked by          fields
//  request   start & !busy           action, block_addr, req_size
//  result    done (one cycle)        alloc_addr, status, segments_used, segments_peak,
//                                    lost_count, lost_bytes, free_total
//  config    cfg_we                  cfg_wdata (fit_mode)
//
// A request scans the table at one entry per cycle through the RAM read port; for N
// stored segments a shift then moves up to N entries one per cycle using read and
// write ports together. A zero-size request goes straight to the done state. Reset
// clears counters; RAM contents are not cleared (only entries below the count are
// read). busy stays high until the done beat.
// The receiver cannot stall: done is a one-cycle strobe and is never held.
module free_segment_table_allocator
    import fsta_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [31:0] block_addr,
    input  logic [31:0] req_size,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    output logic        done,
    output logic [31:0] alloc_addr,
    output logic [1:0]  status,
    output logic [8:0]  segments_used,
    output logic [8:0]  segments_peak,
    output logic [31:0] lost_count,
    output logic [31:0] lost_bytes,
    output logic [31:0] free_total
);

    state_t state_reg, state_next;

    logic              fit_reg;
    logic              act_reg;
    logic [ADDR_W-1:0] addr_reg, size_reg;
    logic [CNT_W-1:0]  count_reg, peak_reg;
    logic [ADDR_W-1:0] lost_cnt_reg, lost_sum_reg, free_sum_reg;
    logic [ADDR_W-1:0] res_addr_reg;
    status_t           res_stat_reg;

    // scan pipeline
    logic [CNT_W-1:0]  iss_reg;
    logic              rv_reg;
    logic [IDX_W-1:0]  rv_idx_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic              found_reg, has_prev_reg, has_next_reg;
    logic [ADDR_W-1:0] prev_start_reg, prev_len_reg, next_start_reg, next_len_reg;

    // shift pipeline
    logic [CNT_W-1:0]  sh_reg, lim_reg;
    logic              wv_reg;
    logic [IDX_W-1:0]  wa_reg;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [ENT_W-1:0]  ram_wdata, ram_rdata;

    fsta_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [ADDR_W-1:0] r_start, r_len;
    assign r_start = ram_rdata[ENT_W-1:ADDR_W];
    assign r_len   = ram_rdata[ADDR_W-1:0];

    // scan evaluation
    logic take, gt, last, scan_end, scan_issue, sh_issue;
    always_comb
    begin
        take = rv_reg && (r_len >= size_reg)
               && (!found_reg || (fit_reg == FIT_BEST && r_len < next_len_reg));
        gt   = rv_reg && (r_start > addr_reg);
        last = rv_reg && ({1'b0, rv_idx_reg} == count_reg - 1'b1);
        if (act_reg == ACT_ALLOC)
        begin
            scan_end = (take && fit_reg == FIT_FIRST) || last;
        end
        else
        begin
            scan_end = gt || last;
        end
        scan_issue = (state_reg == S_SCAN) && (iss_reg < count_reg) && !scan_end;
        sh_issue   = (sh_reg != lim_reg);
    end

    // free decision
    logic              prev_touch, next_touch;
    logic [ADDR_W-1:0] m1, m2, mn;
    always_comb
    begin
        prev_touch = has_prev_reg && (prev_start_reg + prev_len_reg == addr_reg);
        next_touch = has_next_reg && (addr_reg + size_reg == next_start_reg);
        m1 = sat_add(prev_len_reg, size_reg);
        m2 = sat_add(m1, next_len_reg);
        mn = sat_add(next_len_reg, size_reg);
    end

    logic alloc_drop;
    assign alloc_drop = (next_len_reg == size_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req_size == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (act_reg == ACT_ALLOC)
                begin
                    state_next = (found_reg && alloc_drop) ? S_SHDN : S_DONE;
                end
                else if (prev_touch)
                begin
                    state_next = next_touch ? S_SHDN : S_DONE;
                end
                else if (next_touch)
                begin
                    state_next = S_DONE;
                end
                else if (count_reg < CNT_W'(DEPTH))
                begin
                    state_next = S_SHUP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SHUP:
            begin
                if (!sh_issue && !wv_reg)
                begin
                    state_next = S_INS;
                end
            end
            S_SHDN:
            begin
                if (!sh_issue && !wv_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_INS:    state_next = S_DONE;
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // RAM port control
    always_comb
    begin
        ram_raddr = iss_reg[IDX_W-1:0];
        ram_we    = 1'b0;
        ram_waddr = wa_reg;
        ram_wdata = ram_rdata;
        case (state_reg)
            S_SHUP:
            begin
                ram_raddr = IDX_W'(sh_reg - 1'b1);
                ram_we    = wv_reg;
            end
            S_SHDN:
            begin
                ram_raddr = sh_reg[IDX_W-1:0];
                ram_we    = wv_reg;
            end
            S_INS:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg[IDX_W-1:0];
                ram_wdata = {addr_reg, size_reg};
            end
            S_DECIDE:
            begin
                if (act_reg == ACT_ALLOC)
                begin
                    ram_we    = found_reg;
                    ram_waddr = pos_reg[IDX_W-1:0];
                    ram_wdata = {next_start_reg + size_reg, next_len_reg - size_reg};
                end
                else if (prev_touch)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = IDX_W'(pos_reg - 1'b1);
                    ram_wdata = {prev_start_reg, next_touch ? m2 : m1};
                end
                else if (next_touch)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pos_reg[IDX_W-1:0];
                    ram_wdata = {addr_reg, mn};
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = (state_reg == S_DONE);
    assign alloc_addr    = res_addr_reg;
    assign status        = res_stat_reg;
    assign segments_used = count_reg;
    assign segments_peak = peak_reg;
    assign lost_count    = lost_cnt_reg;
    assign lost_bytes    = lost_sum_reg;
    assign free_total    = free_sum_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fit_reg      <= FIT_BEST;
            count_reg    <= '0;
            peak_reg     <= '0;
            lost_cnt_reg <= '0;
            lost_sum_reg <= '0;
            free_sum_reg <= '0;
            rv_reg       <= 1'b0;
            wv_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                fit_reg <= cfg_wdata;
            end
            rv_reg <= scan_issue;
            wv_reg <= ((state_reg == S_SHUP) || (state_reg == S_SHDN)) && sh_issue;
            if (state_reg == S_DECIDE)
            begin
                if (act_reg == ACT_ALLOC)
                begin
                    if (found_reg)
                    begin
                        free_sum_reg <= free_sum_reg - size_reg;
                        if (alloc_drop)
                        begin
                            count_reg <= count_reg - 1'b1;
                        end
                    end
                end
                else if (prev_touch)
                begin
                    if (next_touch)
                    begin
                        free_sum_reg <= free_sum_reg + m2 - prev_len_reg - next_len_reg;
                        count_reg    <= count_reg - 1'b1;
                    end
                    else
                    begin
                        free_sum_reg <= free_sum_reg + m1 - prev_len_reg;
                    end
                end
                else if (next_touch)
                begin
                    free_sum_reg <= free_sum_reg + mn - next_len_reg;
                end
                else if (count_reg < CNT_W'(DEPTH))
                begin
                    free_sum_reg <= free_sum_reg + size_reg;
                    count_reg    <= count_reg + 1'b1;
                    if (peak_reg < count_reg + 1'b1)
                    begin
                        peak_reg <= count_reg + 1'b1;
                    end
                end
                else
                begin
                    lost_cnt_reg <= lost_cnt_reg + 1'b1;
                    lost_sum_reg <= lost_sum_reg + size_reg;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (scan_issue)
        begin
            iss_reg    <= iss_reg + 1'b1;
            rv_idx_reg <= iss_reg[IDX_W-1:0];
        end
        case (state_reg)
            S_IDLE:
            begin
                act_reg      <= action;
                addr_reg     <= block_addr;
                size_reg     <= req_size;
                iss_reg      <= '0;
                pos_reg      <= '0;
                found_reg    <= 1'b0;
                has_prev_reg <= 1'b0;
                has_next_reg <= 1'b0;
                res_addr_reg <= '0;
                res_stat_reg <= STAT_ZERO;
            end
            S_SCAN:
            begin
                if (act_reg == ACT_ALLOC)
                begin
                    if (take)
                    begin
                        found_reg      <= 1'b1;
                        pos_reg        <= {1'b0, rv_idx_reg};
                        next_start_reg <= r_start;
                        next_len_reg   <= r_len;
                    end
                end
                else if (gt)
                begin
                    has_next_reg   <= 1'b1;
                    next_start_reg <= r_start;
                    next_len_reg   <= r_len;
                    pos_reg        <= {1'b0, rv_idx_reg};
                end
                else if (rv_reg)
                begin
                    has_prev_reg   <= 1'b1;
                    prev_start_reg <= r_start;
                    prev_len_reg   <= r_len;
                    pos_reg        <= {1'b0, rv_idx_reg} + 1'b1;
                end
            end
            S_DECIDE:
            begin
                res_stat_reg <= STAT_OK;
                lim_reg      <= count_reg;
                sh_reg       <= pos_reg + 1'b1;
                if (act_reg == ACT_ALLOC)
                begin
                    if (found_reg)
                    begin
                        res_addr_reg <= next_start_reg;
                    end
                    else
                    begin
                        res_stat_reg <= STAT_NOFIT;
                    end
                end
                else if (!prev_touch && !next_touch)
                begin
                    // make room: move entries pos..count-1 up by one
                    sh_reg  <= count_reg;
                    lim_reg <= pos_reg;
                    if (count_reg >= CNT_W'(DEPTH))
                    begin
                        res_stat_reg <= STAT_LOST;
                    end
                end
            end
            S_SHUP:
            begin
                if (sh_issue)
                begin
                    wa_reg <= sh_reg[IDX_W-1:0];
                    sh_reg <= sh_reg - 1'b1;
                end
            end
            S_SHDN:
            begin
                if (sh_issue)
                begin
                    wa_reg <= IDX_W'(sh_reg - 1'b1);
                    sh_reg <= sh_reg + 1'b1;
                end
            end
            default:
            begin
                wa_reg <= wa_reg;
            end
        endcase
    end

endmodule

/* tb/fsta_checker.sv */
// Checker for the free segment table allocator: watches request, config and result
// beats, keeps its own segment table and compares every result. Depends on fsta_pkg.
module fsta_checker
    import fsta_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        action,
    input  logic [31:0] block_addr,
    input  logic [31:0] req_size,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        done,
    input  logic [31:0] alloc_addr,
    input  logic [1:0]  status,
    input  logic [8:0]  segments_used,
    input  logic [8:0]  segments_peak,
    input  logic [31:0] lost_count,
    input  logic [31:0] lost_bytes,
    input  logic [31:0] free_total,
    output int          errors,
    output int          pending,
    output int          results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] addr;
        status_t     stat;
        logic [8:0]  used;
        logic [8:0]  peak;
        logic [31:0] lcnt;
        logic [31:0] lbytes;
        logic [31:0] ftotal;
    } outcome_t;

    logic [31:0] tbl_start [DEPTH];
    logic [31:0] tbl_len [DEPTH];
    int unsigned n_segs, n_peak;
    logic [31:0] n_lost, bytes_lost;
    logic        mode;
    outcome_t    expected_q[$];

    function automatic logic [31:0] clip_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? ALL_ONES : s[31:0];
    endfunction

    function automatic void remove_seg(int unsigned k);
        for (int unsigned j = k; j + 1 < n_segs; j++)
        begin
            tbl_start[j] = tbl_start[j+1];
            tbl_len[j] = tbl_len[j+1];
        end
        n_segs--;
    endfunction

    function automatic outcome_t serve_request(logic act, logic [31:0] a, logic [31:0] sz);
        outcome_t r;
        int unsigned i, pick;
        bit found;
        logic [31:0] sum;
        r = '0;
        r.stat = STAT_OK;
        found = 0;
        pick = 0;
        sum = 0;
        if (sz == 0)
            r.stat = STAT_ZERO;
        else if (act == ACT_ALLOC)
        begin
            for (i = 0; i < n_segs; i++)
            begin
                if (tbl_len[i] >= sz
                    && (!found || (mode == FIT_BEST && tbl_len[i] < tbl_len[pick])))
                begin
                    pick = i;
                    found = 1;
                    if (mode == FIT_FIRST)
                        break;
                end
            end
            if (!found)
                r.stat = STAT_NOFIT;
            else
            begin
                r.addr = tbl_start[pick];
                tbl_start[pick] += sz;
                tbl_len[pick] -= sz;
                if (tbl_len[pick] == 0)
                    remove_seg(pick);
            end
        end
        else
        begin
            for (i = 0; i < n_segs; i++)
                if (tbl_start[i] > a)
                    break;
            if (i > 0 && tbl_start[i-1] + tbl_len[i-1] == a)
            begin
                tbl_len[i-1] = clip_add(tbl_len[i-1], sz);
                if (i < n_segs && a + sz == tbl_start[i])
                begin
                    tbl_len[i-1] = clip_add(tbl_len[i-1], tbl_len[i]);
                    remove_seg(i);
                end
            end
            else if (i < n_segs && a + sz == tbl_start[i])
            begin
                tbl_start[i] = a;
                tbl_len[i] = clip_add(tbl_len[i], sz);
            end
            else if (n_segs < DEPTH)
            begin
                for (int unsigned j = n_segs; j > i; j--)
                begin
                    tbl_start[j] = tbl_start[j-1];
                    tbl_len[j] = tbl_len[j-1];
                end
                n_segs++;
                if (n_peak < n_segs)
                    n_peak = n_segs;
                tbl_start[i] = a;
                tbl_len[i] = sz;
            end
            else
            begin
                n_lost++;
                bytes_lost += sz;
                r.stat = STAT_LOST;
            end
        end
        for (i = 0; i < n_segs; i++)
            sum += tbl_len[i];
        r.used = n_segs[8:0];
        r.peak = n_peak[8:0];
        r.lcnt = n_lost;
        r.lbytes = bytes_lost;
        r.ftotal = sum;
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t e, got;
        if (!rst_n)
        begin
            n_segs = 0;
            n_peak = 0;
            n_lost = 0;
            bytes_lost = 0;
            mode = FIT_BEST;
            errors <= 0;
            results_seen <= 0;
            expected_q.delete();
        end
        else
        begin
            // result first: a new request cannot finish in the cycle it is taken
            if (done)
            begin
                got = '{alloc_addr, status_t'(status), segments_used, segments_peak,
                        lost_count, lost_bytes, free_total};
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0)
                begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("unexpected result beat at %0t", $time);
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (got !== e)
                    begin
                        errors <= errors + 1;
                        if (errors < 10)
                        begin
                            $display("mismatch at %0t", $time);
                            $display("  exp addr=%h st=%0d used=%0d peak=%0d lc=%0d lb=%h ft=%h",
                                     e.addr, e.stat, e.used, e.peak, e.lcnt, e.lbytes,
                                     e.ftotal);
                            $display("  got addr=%h st=%0d used=%0d peak=%0d lc=%0d lb=%h ft=%h",
                                     got.addr, got.stat, got.used, got.peak, got.lcnt,
                                     got.lbytes, got.ftotal);
                        end
                    end
                end
            end
            if (cfg_we)
                mode = cfg_wdata;
            if (start && !busy)
                expected_q.push_back(serve_request(action, block_addr, req_size));
        end
    end
endmodule

/* tb/testbench.sv */
// Stimulus and verdict for free_segment_table_allocator; the fsta_checker instance
// predicts and compares. Depends on fsta_pkg, fsta_checker and the RTL.
module testbench;
    import fsta_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic        action = ACT_ALLOC;
    logic [31:0] block_addr = 0;
    logic [31:0] req_size = 0;
    logic        cfg_we = 0;
    logic        cfg_wdata = 0;
    logic        busy, done;
    logic [31:0] alloc_addr, lost_count, lost_bytes, free_total;
    logic [1:0]  status;
    logic [8:0]  segments_used, segments_peak;
    int          errors, pending, results_seen;
    longint      cycles = 0;
    int          beats = 0;

    localparam longint CYCLE_LIMIT = 4_000_000;

    always #1 clk = ~clk;

    free_segment_table_allocator uut (.*);
    fsta_checker chk (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    // one request beat; inputs move on the falling edge, start drops on a later one
    task automatic issue(logic act, logic [31:0] a, logic [31:0] sz);
        @(negedge clk);
        action <= act;
        block_addr <= a;
        req_size <= sz;
        start <= 1;
        do @(posedge clk); while (busy);
        @(negedge clk);
        start <= 0;
        beats++;
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_mode(logic m);
        drain();
        cfg_wdata <= m;
        cfg_we <= 1;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    // random content in a small address window so frees touch and merge
    task automatic random_phase(int count, int unsigned span);
        int gap;
        for (int k = 0; k < count; k++)
        begin
            int unsigned pick;
            logic [31:0] a, sz;
            pick = $urandom_range(0, 99);
            a = $urandom_range(0, span) * 16;
            sz = $urandom_range(1, 8) * 16;
            if (pick < 3) sz = 0;
            else if (pick < 6) sz = $urandom;
            else if (pick < 8) a = $urandom;
            issue(pick < 55, a, sz);
            if ($urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 12);
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        // directed: zero size, failed alloc, merges, wrap, saturation, ties
        issue(ACT_ALLOC, 0, 0);
        issue(ACT_FREE, 32'h100, 0);
        issue(ACT_ALLOC, 0, 16);
        issue(ACT_FREE, 32'h100, 32'h40);
        issue(ACT_FREE, 32'h200, 32'h40);
        issue(ACT_FREE, 32'h300, 32'h40);
        issue(ACT_FREE, 32'h140, 32'h40);
        issue(ACT_FREE, 32'h1C0, 32'h40);
        issue(ACT_FREE, 32'h280, 32'h80);
        issue(ACT_ALLOC, 0, 32'h10);
        issue(ACT_ALLOC, 0, 32'hFFFF_FFFF);
        issue(ACT_FREE, 32'hFFFF_FFF0, 32'h20);
        issue(ACT_FREE, 32'h8000_0000, 32'hFFFF_FFFF);
        issue(ACT_FREE, 32'h7FFF_F000, 32'h1000);
        issue(ACT_ALLOC, 0, 32'hFFFF_FFFF);
        set_mode(FIT_FIRST);
        issue(ACT_ALLOC, 0, 32'h20);
        issue(ACT_ALLOC, 0, 32'h40);
        set_mode(FIT_BEST);
        issue(ACT_ALLOC, 0, 32'h20);
        issue(ACT_FREE, 32'h0, 32'h20);
        // fill the table past its depth with isolated segments to reach the lost path
        for (int k = 0; k < 260; k++)
            issue(ACT_FREE, 32'h1000_0000 + k * 64, 32 + k[0]);
        issue(ACT_FREE, 32'h2000_0000, 32'hFFFF_FFFF);
        random_phase(40, 300);
        drain();
        // fresh-ish working area: random mixed traffic in both modes
        set_mode(FIT_FIRST);
        random_phase(70, 64);
        set_mode(FIT_BEST);
        random_phase(70, 64);
        set_mode(FIT_FIRST);
        random_phase(40, 1000);
        drain();
        $display("run: %0d request beats, %0d results, both fit modes,", beats, results_seen);
        $display("     table overflow, merges and saturating lengths");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
